[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define PCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Next-cycle implication that also holds across reset.
`define PCD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/pcd_pkg.sv]
// Package: sizes, interface structs and the Q1.15 twiddle tables.
package pcd_pkg;

  localparam int DopN   = 64;
  localparam int MaxP   = 64;
  localparam int DOP_W  = $clog2(DopN);
  localparam int ADDR_W = $clog2(MaxP);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int LAG_W  = 4;
  localparam int SMP_W  = 16;
  localparam int TW_W   = 16;
  localparam int BIN_W  = 23;
  localparam int ACC_W  = 2 * SMP_W + 2 + DOP_W + 2;

  localparam longint unsigned Q30One    = 64'd1073741824;
  localparam longint unsigned Q30HalfPi = 64'd1686629713;

  typedef logic signed [TW_W-1:0] tw_arr_t [DopN];

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic [LAG_W-1:0] lag;
  } pcd_job_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } pcd_rd_req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] a_re;
    logic signed [SMP_W-1:0] a_im;
    logic signed [SMP_W-1:0] b_re;
    logic signed [SMP_W-1:0] b_im;
  } pcd_rd_data_t;

  // Shift-subtract quotient; only used while building the tables.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series of sin or cos on a Q30 angle in [0, pi/2]; elaboration only.
  function automatic longint taylor_q30(longint unsigned a, bit odd);
    longint unsigned term;
    longint unsigned dv;
    longint          sum;
    term = odd ? a : Q30One;
    sum  = longint'(term);
    for (int k = 1; k <= 10; k++) begin
      dv   = odd ? longint'((2 * k) * (2 * k + 1)) : longint'((2 * k - 1) * (2 * k));
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = udiv64(term, dv);
      if ((k & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return sum;
  endfunction

  function automatic logic signed [TW_W-1:0] q30_to_q15(longint v);
    longint unsigned mg;
    longint unsigned q;
    mg = (v < 0) ? longint'(-v) : longint'(v);
    q  = (mg + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return (v < 0) ? -TW_W'(q) : TW_W'(q);
  endfunction

  function automatic tw_arr_t build_tw(bit want_sin);
    tw_arr_t         t;
    longint unsigned qd;
    longint unsigned r;
    longint unsigned a;
    longint          s;
    longint          c;
    longint          cv;
    longint          sv;
    for (int m = 0; m < DopN; m++) begin
      qd = longint'(4 * m) >> DOP_W;
      r  = longint'(4 * m) & longint'(DopN - 1);
      a  = (Q30HalfPi * r) >> DOP_W;
      s  = taylor_q30(a, 1'b1);
      c  = taylor_q30(a, 1'b0);
      case (qd[1:0])
        2'd0:    begin cv = c;  sv = s;  end
        2'd1:    begin cv = -s; sv = c;  end
        2'd2:    begin cv = -c; sv = -s; end
        default: begin cv = s;  sv = -c; end
      endcase
      t[m] = want_sin ? q30_to_q15(sv) : q30_to_q15(cv);
    end
    return t;
  endfunction

  localparam tw_arr_t TwCos = build_tw(1'b0);
  localparam tw_arr_t TwSin = build_tw(1'b1);

endpackage

[hw/rtl/pcd_front.sv]
// Front end: lag register, pulse store, pulse count and job issue.
module pcd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [pcd_pkg::LAG_W-1:0] cfg_data,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [31:0]             in_tdata,
  input  logic                    in_tlast,
  output logic                    job_valid,
  input  logic                    job_ready,
  output pcd_pkg::pcd_job_t       job,
  input  logic                    run_done,
  input  pcd_pkg::pcd_rd_req_t    rd_req,
  output pcd_pkg::pcd_rd_data_t   rd_data
);
  import pcd_pkg::*;

  logic [2*SMP_W-1:0] store_mem [MaxP];
  logic [LAG_W-1:0]   lag_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r;
  logic               acc_in;
  logic               has_room;
  logic [CNT_W-1:0]   cnt_new;
  logic [CNT_W-1:0]   lag_ext;
  pcd_rd_data_t       rd_data_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r && job_ready;
  assign acc_in    = in_tvalid && in_tready;
  assign has_room  = (cnt_r < CNT_W'(MaxP));
  assign cnt_new   = has_room ? cnt_r + CNT_W'(1) : cnt_r;
  assign lag_ext   = CNT_W'(lag_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc_in) cnt_nxt = in_tlast ? '0 : cnt_new;
  end

  assign job_valid = acc_in && in_tlast;
  assign job.lag   = lag_r;
  assign job.used  = (cnt_new > lag_ext) ? cnt_new - lag_ext : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r  <= LAG_W'(1);
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (cfg_valid) lag_r <= cfg_data;
      cnt_r <= cnt_nxt;
      if (job_valid)     busy_r <= 1'b1;
      else if (run_done) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && has_room) store_mem[cnt_r[ADDR_W-1:0]] <= in_tdata;
    {rd_data_r.a_im, rd_data_r.a_re} <= store_mem[rd_req.addr_a];
    {rd_data_r.b_im, rd_data_r.b_re} <= store_mem[rd_req.addr_b];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/pcd_jobq.sv]
// Two-entry job queue between front end and DFT engine.
module pcd_jobq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  pcd_pkg::pcd_job_t wr_job,
  output logic              rd_valid,
  input  logic              rd_ready,
  output pcd_pkg::pcd_job_t rd_job
);
  import pcd_pkg::*;

  pcd_job_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = q_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= wr_job;
  end

endmodule

[hw/rtl/pcd_back.sv]
// DFT engine: one complex multiply-accumulate per cycle while issuing (bins wait on out_tready), bins in natural order.
module pcd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  pcd_pkg::pcd_job_t     job,
  output pcd_pkg::pcd_rd_req_t  rd_req,
  input  pcd_pkg::pcd_rd_data_t rd_data,
  output logic                  run_done,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,
  output logic                  out_tlast
);
  import pcd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_OUT} st_t;

  st_t                       st_r;
  logic [CNT_W-1:0]          used_r, n_r;
  logic [LAG_W-1:0]          lag_r;
  logic [DOP_W-1:0]          k_r, m_r, m1_r;
  logic                      s1_v_r, s2_v_r, s3_v_r;
  logic signed [SMP_W:0]     d_re_r, d_im_r;
  logic signed [TW_W-1:0]    c_r, s_r;
  logic signed [SMP_W+TW_W:0] p_ac_r, p_bs_r, p_bc_r, p_as_r;
  logic signed [ACC_W-1:0]   acc_re_r, acc_im_r;
  logic signed [BIN_W-1:0]   bin_re_r, bin_im_r;
  logic [DOP_W-1:0]          idx_r;
  logic                      last_r, done_r;
  logic signed [BIN_W-1:0]   rnd_re, rnd_im;
  logic [CNT_W-1:0]          addr_b_full;

  function automatic logic signed [BIN_W-1:0] round_sat(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0]    t;
    logic signed [ACC_W-16:0]   q;
    t = v + ACC_W'(16384);
    q = (ACC_W-15)'(t >>> 15);
    if (q > (ACC_W-15)'((1 << (BIN_W-1)) - 1))      return {1'b0, {(BIN_W-1){1'b1}}};
    else if (q < -(ACC_W-15)'(1 << (BIN_W-1)))      return {1'b1, {(BIN_W-1){1'b0}}};
    else                                            return q[BIN_W-1:0];
  endfunction

  assign addr_b_full   = n_r + CNT_W'(lag_r);
  assign rd_req.addr_a = n_r[ADDR_W-1:0];
  assign rd_req.addr_b = addr_b_full[ADDR_W-1:0];
  assign job_ready     = (st_r == ST_IDLE);
  assign rnd_re        = round_sat(acc_re_r);
  assign rnd_im        = round_sat(acc_im_r);
  assign run_done      = done_r;

  // Datapath pipeline: read, difference and twiddle, products, accumulate.
  always_ff @(posedge clk) begin
    m1_r   <= m_r;
    d_re_r <= (SMP_W+1)'(rd_data.a_re) - (SMP_W+1)'(rd_data.b_re);
    d_im_r <= (SMP_W+1)'(rd_data.a_im) - (SMP_W+1)'(rd_data.b_im);
    c_r    <= TwCos[m1_r];
    s_r    <= TwSin[m1_r];
    p_ac_r <= d_re_r * c_r;
    p_bs_r <= d_im_r * s_r;
    p_bc_r <= d_im_r * c_r;
    p_as_r <= d_re_r * s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      out_tvalid <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      s1_v_r <= (st_r == ST_ISSUE);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      done_r <= 1'b0;
      if (s3_v_r) begin
        acc_re_r <= acc_re_r + ACC_W'(p_ac_r) + ACC_W'(p_bs_r);
        acc_im_r <= acc_im_r + ACC_W'(p_bc_r) - ACC_W'(p_as_r);
      end
      unique case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            used_r   <= job.used;
            lag_r    <= job.lag;
            k_r      <= '0;
            n_r      <= '0;
            m_r      <= '0;
            acc_re_r <= '0;
            acc_im_r <= '0;
            st_r     <= (job.used == '0) ? ST_DRAIN : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          n_r <= n_r + CNT_W'(1);
          m_r <= m_r + k_r;
          if (n_r == used_r - CNT_W'(1)) st_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            bin_re_r   <= rnd_re;
            bin_im_r   <= rnd_im;
            idx_r      <= k_r;
            last_r     <= (k_r == DOP_W'(DopN - 1));
            out_tvalid <= 1'b1;
            st_r       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            if (last_r) begin
              done_r <= 1'b1;
              st_r   <= ST_IDLE;
            end else begin
              k_r      <= k_r + DOP_W'(1);
              n_r      <= '0;
              m_r      <= '0;
              acc_re_r <= '0;
              acc_im_r <= '0;
              st_r     <= (used_r == '0) ? ST_DRAIN : ST_ISSUE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tdata = {4'b0, idx_r, bin_im_r, bin_re_r};
  assign out_tlast = last_r;

endmodule

[hw/rtl/pulse_canceller_doppler_fft.sv]
// Top level: pulse canceller followed by a 64-bin Doppler DFT for one range bin.
//
//   channel | dir | fields (low bit first)
//   in_     | in  | tdata: sample_re[15:0], sample_im[31:16]; tlast: last_pulse
//   out_    | out | tdata: bin_re[22:0], bin_im[45:23], bin_index[51:46]; tlast: last_bin
//   cfg_    | in  | data: cancel_lag[3:0]
//
// A pulse that is not last is stored and counted. A last pulse starts a run of 64 bins;
// each bin issues used products (none when used is zero), drains and waits on out_tready,
// where used is the number of canceller differences (one complex MAC per cycle while issuing).
// Input is held off (in_tready low) from the last pulse until the run is reported
// done after the last bin is taken.
// Reset is synchronous: lag returns to 1, pulse count and queue empty.
module pulse_canceller_doppler_fft (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,    // cancel_lag[3:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // sample_re[15:0], sample_im[31:16]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // bin_re[22:0], bin_im[45:23], bin_index[51:46]
  output logic        out_tlast
);
  import pcd_pkg::*;

  logic          fq_valid, fq_ready, qb_valid, qb_ready, run_done;
  pcd_job_t      fq_job, qb_job;
  pcd_rd_req_t   rd_req;
  pcd_rd_data_t  rd_data;

  pcd_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job),
    .run_done, .rd_req, .rd_data
  );

  pcd_jobq u_jobq (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  pcd_back u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .rd_req, .rd_data, .run_done,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

[hw/rtl/pcd_checker.sv]
// Port-level checker for the canceller/DFT block, bound to the top level.
`include "assert_macros.svh"
module pcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);
  `PCD_ASSERT_IMPL(a_last_is_top_bin, clk, rst_n, out_tvalid && out_tlast, out_tdata[51:46] == 6'd63)
  `PCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `PCD_ASSERT_IMPL(a_no_input_during_run, clk, rst_n, out_tvalid, !in_tready)
  `PCD_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, !rst_n, !out_tvalid)
endmodule

bind pulse_canceller_doppler_fft pcd_checker u_pcd_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

[tb/sv/pulse_canceller_doppler_fft_chk.sv]
// Checker: watches the sample, bin and lag channels, predicts Doppler bins and compares.
module pulse_canceller_doppler_fft_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          bins_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcd_pkg::*;

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic [DOP_W-1:0]        idx;
    logic                    last;
  } bin_t;

  localparam longint BinHi = 64'sd4194303;
  localparam longint BinLo = -64'sd4194304;

  int                 twc [DopN];
  int                 tws [DopN];
  logic [LAG_W-1:0]   lag_q;
  int                 smp_re [MaxP];
  int                 smp_im [MaxP];
  int                 n_pulses;
  bin_t               bin_q [$];

  // Q30 Taylor series, same formulation the twiddle tables are specified with
  function automatic longint series_q30(longint unsigned a, bit odd);
    longint unsigned term, dv;
    longint sum;
    term = odd ? a : 64'd1073741824;
    sum  = longint'(term);
    for (int k = 1; k <= 10; k++) begin
      dv   = odd ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = term / dv;
      if (k % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    return sum;
  endfunction

  function automatic int to_q15(longint v);
    longint unsigned mg, q;
    mg = (v < 0) ? -v : v;
    q  = (mg + 16384) >> 15;
    if (q > 32767) q = 32767;
    return (v < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic longint round_clip(longint acc);
    longint t, q;
    t = acc + 16384;
    q = (t >= 0) ? t / 32768 : -((-t + 32767) / 32768);
    if (q > BinHi) q = BinHi;
    if (q < BinLo) q = BinLo;
    return q;
  endfunction

  initial begin
    longint unsigned a, r, qd;
    longint s, c, cv, sv;
    for (int m = 0; m < DopN; m++) begin
      qd = (4 * m) / DopN;
      r  = 4 * m - qd * DopN;
      a  = (64'd1686629713 * r) / DopN;
      s  = series_q30(a, 1'b1);
      c  = series_q30(a, 1'b0);
      case (qd % 4)
        0: begin cv = c; sv = s; end
        1: begin cv = -s; sv = c; end
        2: begin cv = -c; sv = -s; end
        default: begin cv = s; sv = -c; end
      endcase
      twc[m] = to_q15(cv);
      tws[m] = to_q15(sv);
    end
  end

  task automatic predict_bins();
    int used;
    int dre [DopN];
    int dim [DopN];
    longint are, aim;
    bin_t b;
    used = (n_pulses > lag_q) ? n_pulses - lag_q : 0;
    if (used > DopN) used = DopN;
    for (int n = 0; n < used; n++) begin
      dre[n] = smp_re[n] - smp_re[n + lag_q];
      dim[n] = smp_im[n] - smp_im[n + lag_q];
    end
    for (int k = 0; k < DopN; k++) begin
      are = 0;
      aim = 0;
      for (int n = 0; n < used; n++) begin
        are += longint'(dre[n]) * twc[(k * n) % DopN] + longint'(dim[n]) * tws[(k * n) % DopN];
        aim += longint'(dim[n]) * twc[(k * n) % DopN] - longint'(dre[n]) * tws[(k * n) % DopN];
      end
      b.re   = BIN_W'(round_clip(are));
      b.im   = BIN_W'(round_clip(aim));
      b.idx  = DOP_W'(k);
      b.last = (k == DopN - 1);
      bin_q.push_back(b);
    end
    n_pulses = 0;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    bin_t w;
    if (!rst_n) begin
      lag_q    <= 4'd1;
      n_pulses = 0;
      bin_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) lag_q <= cfg_data;
      if (out_tvalid && out_tready) begin
        if (bin_q.size() == 0) begin
          $display("mismatch: unexpected bin %0d", out_tdata[51:46]);
          fail_count++;
        end else begin
          w = bin_q.pop_front();
          if ($signed(out_tdata[22:0]) != w.re) report("bin_re", $signed(out_tdata[22:0]), w.re);
          if ($signed(out_tdata[45:23]) != w.im)
            report("bin_im", $signed(out_tdata[45:23]), w.im);
          if (out_tdata[51:46] != w.idx) report("bin_index", out_tdata[51:46], w.idx);
          if (out_tlast != w.last) report("last_bin", out_tlast, w.last);
        end
      end
      if (in_tvalid && in_tready) begin
        if (n_pulses < MaxP) begin
          smp_re[n_pulses] = $signed(in_tdata[15:0]);
          smp_im[n_pulses] = $signed(in_tdata[31:16]);
          n_pulses++;
        end
        if (in_tlast) predict_bins();
      end
    end
    bins_pending <= bin_q.size();
  end
endmodule

[tb/sv/pulse_canceller_doppler_fft_tb.sv]
// Testbench top: drives pulse runs and lag writes, stalls the bin sink, gives the verdict.
module pulse_canceller_doppler_fft_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          bins_pending;
  int          hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pulse_canceller_doppler_fft u_top (.*);
  pulse_canceller_doppler_fft_chk u_chk (.*);

  task automatic write_lag(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one pulse request; gap drawn before it
  task automatic send_pulse(logic [15:0] re, logic [15:0] im, logic last, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // advance the clock before polling so the prediction of the last request is counted
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bins_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word(int style);
    case (style)
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_run(int pulses, int style, bit gaps);
    for (int i = 0; i < pulses; i++)
      send_pulse(rand_word(style == 2 ? (i % 2) : 2), rand_word(style == 2 ? ((i + 1) % 2) : 2),
                 i == pulses - 1, gaps);
  endtask

  // bin sink: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
    end
  end

  initial begin
    int sent;
    int plen;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: single pulse, lag reset default, extremes
    send_run(1, 2, 1'b0);
    send_run(2, 2, 1'b0);
    wait_drained();
    write_lag(4'd0);
    send_run(3, 2, 1'b0);
    wait_drained();
    write_lag(4'd15);
    send_run(15, 0, 1'b0);
    wait_drained();
    write_lag(4'd1);
    hold_cycles <= 300;
    send_run(8, 2, 1'b0);
    // second run is offered while the sink holds off
    send_run(5, 3, 1'b0);
    // alternating extremes at an even lag; store overflow with a dropped last pulse
    wait_drained();
    sent = 34;
    write_lag(4'd2);
    send_run(70, 2, 1'b1);
    sent += 70;
    wait_drained();
    while (sent < 430) begin
      write_lag(4'($urandom_range(0, 15)));
      for (int r = 0; r < 3 && sent < 430; r++) begin
        plen = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 20);
        send_run(plen, ($urandom_range(0, 7) == 0) ? 2 : 3, ($urandom_range(0, 3) != 0));
        sent += plen;
      end
      wait_drained();
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end
endmodule
